// ===== hw/rtl/rup_pkg.sv =====
package rup_pkg;

    // clamp for the remaining-bytes count
    localparam logic [15:0] MAX_DATAGRAM = 16'd65535;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    typedef enum logic [2:0] {
        PH_TAG  = 3'd0,
        PH_TAG2 = 3'd1,
        PH_IDHI = 3'd2,
        PH_IDLO = 3'd3,
        PH_MARK = 3'd4,
        PH_PAY  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_REQUEST = 3'd0,
        KIND_MISSING = 3'd1,
        KIND_HEADER  = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_CORRUPT = 3'd4
    } kind_t;

    typedef struct packed {
        logic               store_empty;
        logic signed [31:0] expected_id;
        logic [15:0]        bytes_left;
        logic [7:0]         rx_byte;
    } in_item_t;

    typedef struct packed {
        kind_t              record_kind;
        logic signed [31:0] record_id;
        logic               keep;
        logic [14:0]        payload_length;
        logic [7:0]         data_byte;
        logic               last_of_record;
    } result_t;

endpackage

// ===== hw/rtl/reliable_udp_record_parser.sv =====
// channel   | ports                | tdata fields (low bit up)                     | side
// ----------+----------------------+-----------------------------------------------+-----
// in beat   | s_axis_t*            | rx_byte, bytes_left, expected_id, store_empty | tuser -
// out beat  | m_axis_t*            | record_id, keep, payload_length, data_byte    | tuser kind, tlast
//
// one input beat per cycle while the output register is free; each beat gives zero or one output beat
// a beat passes the input register, then the parse logic into the output register
// the parse state sits in one register set updated once per beat, so beats chain freely
// aresetn is synchronous; it empties both registers and returns to tag parsing
// a stalled output holds every beat, also one that emits nothing; the input register absorbs one more
module reliable_udp_record_parser
    import rup_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // rx_byte[7:0], bytes_left[23:8], expected_id[55:24], store_empty[56], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // record_id[31:0], keep[32], payload_length[47:33], data_byte[55:48]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // record_kind[2:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    output logic                 m_axis_tlast
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     fire;
    logic     emit;
    result_t  result;
    result_t  m_result;

    assign s_item.rx_byte     = s_axis_tdata[7:0];
    assign s_item.bytes_left  = s_axis_tdata[23:8];
    assign s_item.expected_id = $signed(s_axis_tdata[55:24]);
    assign s_item.store_empty = s_axis_tdata[56];

    assign fire = item_valid && out_free;

    rup_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    rup_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    rup_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && emit),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {m_result.data_byte, m_result.payload_length,
                           m_result.keep, m_result.record_id};
    assign m_axis_tuser = m_result.record_kind;
    assign m_axis_tlast = m_result.last_of_record;

endmodule

// ===== hw/rtl/rup_in_reg.sv =====
module rup_in_reg
    import rup_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/rup_parser.sv =====
module rup_parser
    import rup_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  in_item_t item,
    output logic     emit,
    output result_t  result
);

    localparam logic signed [33:0] WRAP_LO = -34'sd32768;
    localparam logic signed [33:0] WRAP_HI = 34'sd32768;

    phase_t      phase_reg, phase_next;
    logic [7:0]  tag_high_reg, tag_high_next;
    logic [14:0] rec_len_reg, rec_len_next;
    logic [7:0]  id_high_reg, id_high_next;
    logic [1:0]  marker_reg, marker_next;
    logic [14:0] pay_left_reg, pay_left_next;
    logic [31:0] highest_reg, highest_next;
    logic        keep_flag_reg, keep_flag_next;
    logic        skip_reg, skip_next;

    logic [15:0] bl;
    logic        last;
    logic [15:0] rem;
    logic        tag_taken;
    logic [14:0] tag_len;
    logic        tag_short;
    logic        corrupt;
    logic [31:0] id_base;
    logic signed [33:0] id_diff;
    logic [31:0] wide_id;
    logic        id_keep;
    logic [14:0] hdr_plen;
    logic [1:0]  marker_dec;
    logic [14:0] pay_dec;

    // byte count and tag decode
    always_comb begin
        bl   = (item.bytes_left > MAX_DATAGRAM) ? MAX_DATAGRAM : item.bytes_left;
        last = (bl <= 16'd1);
        rem  = (bl != 16'd0) ? bl - 16'd1 : 16'd0;

        tag_taken = 1'b0;
        tag_len   = {7'd0, item.rx_byte};
        if (phase_reg == PH_TAG && !item.rx_byte[7]) begin
            tag_taken = 1'b1;
        end
        if (phase_reg == PH_TAG2) begin
            tag_taken = 1'b1;
            tag_len   = {tag_high_reg[6:0], item.rx_byte};
        end

        if (tag_len == 15'd1) begin
            tag_short = 1'b1;
        end else if (tag_len < 15'd4) begin
            tag_short = (rem < 16'd2);
        end else begin
            tag_short = (rem < {1'b0, tag_len});
        end

        corrupt = !skip_reg &&
                  ((phase_reg == PH_TAG && item.rx_byte[7] && last) ||
                   (tag_taken && tag_len != 15'd0 && tag_short));
    end

    // widen the 16-bit id around the highest accepted id
    always_comb begin
        id_base = {highest_reg[31:16], id_high_reg, item.rx_byte};
        id_diff = $signed({{2{id_base[31]}}, id_base})
                - $signed({{2{highest_reg[31]}}, highest_reg});
        if (id_diff < WRAP_LO) begin
            wide_id = id_base + 32'h0001_0000;
        end else if (id_diff > WRAP_HI) begin
            wide_id = id_base - 32'h0001_0000;
        end else begin
            wide_id = id_base;
        end
        id_keep    = ($signed(wide_id) >= item.expected_id);
        hdr_plen   = rec_len_reg - 15'd4;
        marker_dec = marker_reg - 2'd1;
        pay_dec    = pay_left_reg - 15'd1;
    end

    // next state
    always_comb begin
        phase_next     = phase_reg;
        tag_high_next  = tag_high_reg;
        rec_len_next   = rec_len_reg;
        id_high_next   = id_high_reg;
        marker_next    = marker_reg;
        pay_left_next  = pay_left_reg;
        highest_next   = highest_reg;
        keep_flag_next = keep_flag_reg;
        skip_next      = skip_reg;

        if (!skip_reg) begin
            if (tag_taken) begin
                rec_len_next = tag_len;
                if (tag_len == 15'd0) begin
                    phase_next = PH_TAG;
                end else if (!tag_short) begin
                    phase_next = PH_IDHI;
                end
            end
            unique case (phase_reg)
                PH_TAG: begin
                    if (item.rx_byte[7] && !last) begin
                        tag_high_next = item.rx_byte;
                        phase_next    = PH_TAG2;
                    end
                end
                PH_TAG2: ;
                PH_IDHI: begin
                    id_high_next = item.rx_byte;
                    phase_next   = PH_IDLO;
                end
                PH_IDLO: begin
                    if (rec_len_reg >= 15'd3 && id_keep &&
                        ($signed(wide_id) > $signed(highest_reg) || item.store_empty)) begin
                        highest_next = wide_id;
                    end
                    if (rec_len_reg < 15'd4) begin
                        phase_next = PH_TAG;
                    end else begin
                        keep_flag_next = id_keep;
                        pay_left_next  = hdr_plen;
                        marker_next    = 2'd2;
                        phase_next     = PH_MARK;
                    end
                end
                PH_MARK: begin
                    marker_next = marker_dec;
                    if (marker_dec == 2'd0) begin
                        phase_next = (pay_left_reg != 15'd0) ? PH_PAY : PH_TAG;
                    end
                end
                PH_PAY: begin
                    pay_left_next = pay_dec;
                    if (pay_dec == 15'd0) begin
                        phase_next = PH_TAG;
                    end
                end
                default: phase_next = PH_TAG;
            endcase
        end

        if (corrupt) begin
            phase_next = PH_TAG;
            skip_next  = !last;
        end
        if (last) begin
            phase_next = PH_TAG;
            skip_next  = 1'b0;
        end
    end

    // result
    always_comb begin
        emit   = 1'b0;
        result = '{record_kind: KIND_REQUEST, record_id: '0, keep: 1'b0,
                   payload_length: '0, data_byte: '0, last_of_record: 1'b0};
        if (corrupt) begin
            emit                  = 1'b1;
            result.record_kind    = KIND_CORRUPT;
            result.last_of_record = 1'b1;
        end else if (!skip_reg && phase_reg == PH_IDLO) begin
            emit             = 1'b1;
            result.record_id = $signed(wide_id);
            result.keep      = id_keep;
            if (rec_len_reg < 15'd4) begin
                result.record_kind    = (rec_len_reg[0]) ? KIND_MISSING : KIND_REQUEST;
                result.last_of_record = 1'b1;
            end else begin
                result.record_kind    = KIND_HEADER;
                result.payload_length = hdr_plen;
                result.last_of_record = !id_keep || (hdr_plen == 15'd0);
            end
        end else if (!skip_reg && phase_reg == PH_PAY && keep_flag_reg) begin
            emit                  = 1'b1;
            result.record_kind    = KIND_PAYLOAD;
            result.keep           = 1'b1;
            result.data_byte      = item.rx_byte;
            result.last_of_record = (pay_left_reg == 15'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TAG;
            tag_high_reg  <= '0;
            rec_len_reg   <= '0;
            id_high_reg   <= '0;
            marker_reg    <= '0;
            pay_left_reg  <= '0;
            highest_reg   <= '0;
            keep_flag_reg <= 1'b0;
            skip_reg      <= 1'b0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            tag_high_reg  <= tag_high_next;
            rec_len_reg   <= rec_len_next;
            id_high_reg   <= id_high_next;
            marker_reg    <= marker_next;
            pay_left_reg  <= pay_left_next;
            highest_reg   <= highest_next;
            keep_flag_reg <= keep_flag_next;
            skip_reg      <= skip_next;
        end
    end

endmodule

// ===== hw/rtl/rup_out_reg.sv =====
module rup_out_reg
    import rup_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
